// File: rtl/mhpq_pkg.sv
// Shared types and codes for the max-heap priority queue.
`default_nettype none
package mhpq_pkg;

    localparam int KEY_W   = 32;
    localparam int COUNT_W = 7;

    typedef enum logic {
        CMD_INSERT  = 1'b0,
        CMD_EXTRACT = 1'b1
    } cmd_code_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef struct packed {
        cmd_code_t                command;
        logic signed [KEY_W-1:0]  key_in;
    } request_t;

    typedef struct packed {
        logic signed [KEY_W-1:0]  key_out;
        status_t                  status;
        logic [COUNT_W-1:0]       entry_count;
    } result_t;

    typedef struct packed {
        logic                     insert;
        logic                     extract;
        logic signed [KEY_W-1:0]  key;
    } cell_op_t;

endpackage
`default_nettype wire

// File: rtl/mhpq_cell.sv
// One storage cell of the sorted key row.
`default_nettype none
module mhpq_cell
    import mhpq_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire cell_op_t                op,
    input  wire logic                    left_keep,
    input  wire logic                    left_valid,
    input  wire logic signed [KEY_W-1:0] left_key,
    input  wire logic                    right_valid,
    input  wire logic signed [KEY_W-1:0] right_key,
    output logic                         keep,
    output logic                         valid,
    output logic signed [KEY_W-1:0]      key
);

    logic                    valid_reg;
    logic                    valid_next;
    logic signed [KEY_W-1:0] key_reg;
    logic signed [KEY_W-1:0] key_next;

    assign keep  = valid_reg && (key_reg >= op.key);
    assign valid = valid_reg;
    assign key   = key_reg;

    always_comb
    begin
        valid_next = valid_reg;
        key_next   = key_reg;
        if (op.insert)
        begin
            if (!keep)
            begin
                if (left_keep)
                begin
                    valid_next = 1'b1;
                    key_next   = op.key;
                end
                else
                begin
                    valid_next = left_valid;
                    key_next   = left_key;
                end
            end
        end
        else if (op.extract)
        begin
            valid_next = right_valid;
            key_next   = right_key;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

endmodule
`default_nettype wire

// File: rtl/max_heap_priority_queue.sv
// Top level of the max-heap priority queue: cell row, count and result beat.
// Commands are never stalled: the result beat is strobed on done in the
// cycle after start, and busy stays low, so a new command may follow in
// every cycle. That rate comes from the row of CAPACITY cells,
// which keeps keys sorted largest first and updates all cells in parallel on
// each insert (shift right past the new key) or extract (shift left). The
// receiver cannot stall; each result beat lasts exactly one cycle.
`default_nettype none
module max_heap_priority_queue
    import mhpq_pkg::*;
#(
    parameter int CAPACITY = 64
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     start,
    input  wire request_t request,
    output logic          busy,
    output logic          done,
    output result_t       result
);

    localparam int CW = $clog2(CAPACITY + 1);

    logic                    keep_w  [CAPACITY];
    logic                    valid_w [CAPACITY];
    logic signed [KEY_W-1:0] key_w   [CAPACITY];

    logic [CW-1:0]           count_reg;
    logic [CW-1:0]           count_next;
    logic                    done_reg;
    result_t                 result_reg;
    result_t                 result_next;
    logic [CW+COUNT_W-1:0]   count_wide;

    logic     accept;
    logic     is_full;
    logic     is_empty;
    cell_op_t op;

    assign busy     = 1'b0;
    assign accept   = start && !busy;
    assign is_full  = (count_reg == CW'(CAPACITY));
    assign is_empty = (count_reg == '0);

    always_comb
    begin
        op.insert  = accept && (request.command == CMD_INSERT) && !is_full;
        op.extract = accept && (request.command == CMD_EXTRACT) && !is_empty;
        op.key     = request.key_in;
    end

    generate
        for (genvar i = 0; i < CAPACITY; i++)
        begin : g_cell
            logic                    lk;
            logic                    lv;
            logic signed [KEY_W-1:0] lkey;
            logic                    rv;
            logic signed [KEY_W-1:0] rkey;
            if (i == 0)
            begin : g_first
                assign lk   = 1'b1;
                assign lv   = 1'b0;
                assign lkey = '0;
            end
            else
            begin : g_mid
                assign lk   = keep_w[i-1];
                assign lv   = valid_w[i-1];
                assign lkey = key_w[i-1];
            end
            if (i == CAPACITY - 1)
            begin : g_last
                assign rv   = 1'b0;
                assign rkey = '0;
            end
            else
            begin : g_inner
                assign rv   = valid_w[i+1];
                assign rkey = key_w[i+1];
            end
            mhpq_cell u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .op          (op),
                .left_keep   (lk),
                .left_valid  (lv),
                .left_key    (lkey),
                .right_valid (rv),
                .right_key   (rkey),
                .keep        (keep_w[i]),
                .valid       (valid_w[i]),
                .key         (key_w[i])
            );
        end
    endgenerate

    always_comb
    begin
        count_next = count_reg;
        if (op.insert)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (op.extract)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_comb
    begin
        count_wide              = {{COUNT_W{1'b0}}, count_next};
        result_next.key_out     = '0;
        result_next.status      = ST_OK;
        result_next.entry_count = count_wide[COUNT_W-1:0];
        if (request.command == CMD_INSERT)
        begin
            if (is_full)
            begin
                result_next.status = ST_FULL;
            end
        end
        else
        begin
            if (is_empty)
            begin
                result_next.status = ST_EMPTY;
            end
            else
            begin
                result_next.key_out = key_w[0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            result_reg <= result_next;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule
`default_nettype wire

// File: rtl/mhpq_checker.sv
// Port-level checks for the max-heap priority queue, bound to the top level.
`default_nettype none
module mhpq_checker
    import mhpq_pkg::*;
#(
    parameter int CAPACITY = 64
)
(
    input wire logic     clk,
    input wire logic     rst_n,
    input wire logic     start,
    input wire request_t request,
    input wire logic     busy,
    input wire logic     done,
    input wire result_t  result
);

    a_beat_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> done)
        else $error("command gave no result beat");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy))
        else $error("result beat without a command");

    a_empty_beat: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status == ST_EMPTY) |->
            (result.key_out == '0 && result.entry_count == '0))
        else $error("empty extract beat carries data");

    a_insert_key: assert property (@(posedge clk) disable iff (!rst_n)
        (done && $past(request.command) == CMD_INSERT) |->
            (result.key_out == '0 && result.status != ST_EMPTY))
        else $error("insert beat carries a key or empty status");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (done && $past(done) && result.status == ST_OK
            && $past(request.command) == CMD_EXTRACT) |->
            (result.entry_count + 7'd1 == $past(result.entry_count)))
        else $error("extract did not drop the count by one");

endmodule

bind max_heap_priority_queue mhpq_checker #(.CAPACITY(CAPACITY)) u_mhpq_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .request (request),
    .busy    (busy),
    .done    (done),
    .result  (result)
);
`default_nettype wire

// File: tb/sv/tb_top.sv
// Testbench for the max-heap priority queue: directed and random command beats checked
// against a heap predictor.
module tb_top;
    import mhpq_pkg::*;

    localparam int HEAP_DEPTH = 64;
    localparam int RANDOM_ITEMS = 950;
    localparam int SETTLE_CYCLES = 16;

    typedef struct {
        request_t req;
        int       gap;
        bit       hold_for_drain;
    } cmd_beat_t;

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     start = 1'b0;
    request_t request = '0;
    logic     busy;
    logic     done;
    result_t  result;

    cmd_beat_t pending_cmds[$];
    result_t   predicted_results[$];
    cmd_beat_t staged;
    bit        armed = 1'b0;
    int        idle_left = 0;
    int        plan_size = 0;
    int        fail_count = 0;
    int unsigned accepted_cnt = 0;
    int unsigned received_cnt = 0;

    logic signed [KEY_W-1:0] heap_keys [HEAP_DEPTH];
    int heap_count = 0;

    max_heap_priority_queue #(
        .CAPACITY(HEAP_DEPTH)
    ) u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .request(request),
        .busy   (busy),
        .done   (done),
        .result (result)
    );

    always #5 clk = ~clk;

    function automatic void swap_keys(int a, int b);
        logic signed [KEY_W-1:0] tmp;
        tmp = heap_keys[a];
        heap_keys[a] = heap_keys[b];
        heap_keys[b] = tmp;
    endfunction

    function automatic result_t heap_apply(request_t req);
        result_t res;
        int pos;
        int parent;
        int best;
        int left;
        int right;
        bit moving;
        res.key_out = '0;
        res.status = ST_OK;
        if (req.command == CMD_INSERT)
        begin
            if (heap_count >= HEAP_DEPTH)
                res.status = ST_FULL;
            else
            begin
                heap_keys[heap_count] = req.key_in;
                pos = heap_count;
                heap_count++;
                moving = 1'b1;
                while (moving && pos != 0)
                begin
                    parent = (pos - 1) / 2;
                    if (heap_keys[pos] <= heap_keys[parent])
                        moving = 1'b0;
                    else
                    begin
                        swap_keys(pos, parent);
                        pos = parent;
                    end
                end
            end
        end
        else
        begin
            if (heap_count == 0)
                res.status = ST_EMPTY;
            else
            begin
                res.key_out = heap_keys[0];
                heap_count--;
                heap_keys[0] = heap_keys[heap_count];
                pos = 0;
                moving = 1'b1;
                while (moving)
                begin
                    best = pos;
                    left = 2 * pos + 1;
                    right = 2 * pos + 2;
                    if (left < heap_count && heap_keys[left] > heap_keys[best])
                        best = left;
                    if (right < heap_count && heap_keys[right] > heap_keys[best])
                        best = right;
                    if (best == pos)
                        moving = 1'b0;
                    else
                    begin
                        swap_keys(pos, best);
                        pos = best;
                    end
                end
            end
        end
        res.entry_count = COUNT_W'(heap_count);
        return res;
    endfunction

    function automatic logic signed [KEY_W-1:0] pick_key();
        case ($urandom_range(0, 7))
            0: return 32'sh7FFF_FFFF;
            1: return 32'sh8000_0000;
            2: return $signed($urandom_range(0, 8)) - 4;
            3: return $signed($urandom_range(0, 200)) - 100;
            default: return $urandom;
        endcase
    endfunction

    function automatic int pick_gap(bit idle_on);
        int roll;
        roll = $urandom_range(0, 99);
        if (!idle_on || roll < 50)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic void add_cmd(cmd_code_t cmd, logic signed [KEY_W-1:0] key, int gap,
                                    bit hold_for_drain);
        cmd_beat_t b;
        b.req.command = cmd;
        b.req.key_in = key;
        b.gap = gap;
        b.hold_for_drain = hold_for_drain;
        pending_cmds = {pending_cmds, b};
        if (cmd == CMD_INSERT && plan_size < HEAP_DEPTH)
            plan_size++;
        else if (cmd == CMD_EXTRACT && plan_size > 0)
            plan_size--;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : drive
        logic keep_start;
        logic launch;
        bit   accepting;
        if (!rst_n)
        begin
            start <= 1'b0;
            request <= '0;
            armed = 1'b0;
            idle_left = 0;
        end
        else
        begin
            keep_start = start;
            launch = 1'b0;
            accepting = start && !busy;
            if (accepting)
            begin
                predicted_results = {predicted_results, heap_apply(request)};
                accepted_cnt <= accepted_cnt + 1;
                keep_start = 1'b0;
            end
            if (!keep_start)
            begin
                if (!armed && pending_cmds.size() != 0)
                begin
                    staged = pending_cmds.pop_front();
                    idle_left = staged.gap;
                    armed = 1'b1;
                end
                if (armed)
                begin
                    if (idle_left != 0)
                        idle_left--;
                    else if (!staged.hold_for_drain ||
                             (!accepting && accepted_cnt == received_cnt))
                    begin
                        launch = 1'b1;
                        armed = 1'b0;
                    end
                end
            end
            start <= keep_start || launch;
            if (launch)
                request <= staged.req;
        end
    end

    always @(posedge clk)
    begin : monitor
        result_t want;
        if (rst_n && done)
        begin
            if (predicted_results.size() == 0)
            begin
                $error("unexpected result beat: key_out %0d status %0d entry_count %0d",
                       result.key_out, result.status, result.entry_count);
                fail_count++;
            end
            else
            begin
                want = predicted_results.pop_front();
                received_cnt <= received_cnt + 1;
                if (result.key_out !== want.key_out)
                begin
                    $error("key_out expected %0d got %0d", want.key_out, result.key_out);
                    fail_count++;
                end
                if (result.status !== want.status)
                begin
                    $error("status expected %0d got %0d", want.status, result.status);
                    fail_count++;
                end
                if (result.entry_count !== want.entry_count)
                begin
                    $error("entry_count expected %0d got %0d", want.entry_count,
                           result.entry_count);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        #5_000_000;
        $display("max_heap_priority_queue regression: fail");
        $finish;
    end

    initial
    begin : stimulus
        int n_items;
        int mode;
        int count;
        int ins_pct;
        bit idle_on;
        bit drain_first;
        add_cmd(CMD_EXTRACT, 32'sh0000_0000, 0, 1'b0);
        add_cmd(CMD_EXTRACT, 32'shFFFF_FFFF, 0, 1'b0);
        add_cmd(CMD_INSERT, 32'sh7FFF_FFFF, 0, 1'b0);
        add_cmd(CMD_INSERT, 32'sh8000_0000, 2, 1'b0);
        add_cmd(CMD_INSERT, 32'sh0000_0000, 0, 1'b0);
        add_cmd(CMD_INSERT, 32'shFFFF_FFFF, 0, 1'b0);
        add_cmd(CMD_INSERT, 32'sh0000_0001, 0, 1'b1);
        add_cmd(CMD_INSERT, 32'sh0000_0005, 0, 1'b0);
        add_cmd(CMD_INSERT, 32'sh0000_0005, 1, 1'b0);
        add_cmd(CMD_INSERT, 32'sh0000_0005, 0, 1'b0);
        add_cmd(CMD_INSERT, 32'sh7FFF_FFFF, 0, 1'b0);
        add_cmd(CMD_INSERT, 32'sh8000_0000, 0, 1'b0);
        for (int i = 0; i < 10; i++)
            add_cmd(CMD_EXTRACT, pick_key(), i % 3, 1'b0);
        add_cmd(CMD_EXTRACT, 32'sh5A5A_A5A5, 0, 1'b0);

        n_items = 0;
        while (n_items < RANDOM_ITEMS)
        begin
            mode = $urandom_range(0, 9);
            idle_on = $urandom_range(0, 3) != 0;
            drain_first = $urandom_range(0, 7) == 0;
            if (mode == 0)
            begin
                count = HEAP_DEPTH - plan_size + $urandom_range(1, 3);
                ins_pct = 100;
            end
            else if (mode == 1)
            begin
                count = plan_size + $urandom_range(1, 2);
                ins_pct = 0;
            end
            else
            begin
                count = $urandom_range(1, 24);
                ins_pct = $urandom_range(20, 80);
            end
            for (int i = 0; i < count; i++)
                add_cmd(($urandom_range(0, 99) < ins_pct) ? CMD_INSERT : CMD_EXTRACT,
                        pick_key(), pick_gap(idle_on), drain_first && i == 0);
            n_items += count;
        end

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        do
            @(posedge clk);
        while (pending_cmds.size() != 0 || armed || start || accepted_cnt != received_cnt);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (predicted_results.size() != 0)
        begin
            $error("%0d predicted results never arrived", predicted_results.size());
            fail_count++;
        end
        if (fail_count == 0)
            $display("max_heap_priority_queue regression: pass");
        else
            $display("max_heap_priority_queue regression: fail");
        $finish;
    end

endmodule

// File: filelist.f
rtl/mhpq_pkg.sv
rtl/mhpq_cell.sv
rtl/max_heap_priority_queue.sv
rtl/mhpq_checker.sv
tb/sv/tb_top.sv
